@@ hdl/mwo_pkg.sv @@
// Package for the multi-wave audio oscillator: register indexes, wave mode codes,
// the configuration struct and the 24-bit saturation helper.
// Used by mwo_gen and the top level; depends on nothing.
package mwo_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 3'd4;

  // Wave mode codes; the fourth code generates nothing
  localparam logic [1:0] MODE_SAW  = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_RECT = 2'd2;

  localparam logic signed [15:0] AMP_RESET = 16'sh7FFF;

  // Q3.20 constants, wide enough for the unsaturated update sums
  localparam logic signed [25:0] Q_ONE     = 26'sd1048576;
  localparam logic signed [25:0] Q_TWO     = 26'sd2097152;
  localparam logic signed [26:0] CNT_MIN   = -27'sd33554432;
  localparam logic signed [26:0] CNT_DECR  = 27'sd256;

  typedef struct packed {
    logic [1:0]         wave_mode;
    logic signed [15:0] amplitude;
    logic [21:0]        phase_step;
    logic [23:0]        half_period;
    logic signed [15:0] pulse_width;
  } cfg_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/mwo_gen.sv @@
// Oscillator state and per-sample generator: saw, triangle and rectangle.
// Gives the sample of the current state and advances the state on adv.
// Depends on mwo_pkg.
module mwo_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  mwo_pkg::cfg_t       cfg,
  input  logic                adv,
  output logic signed [24:0]  osc
);

  logic signed [23:0] osc_value_r, osc_value_nxt;
  logic               tri_falling_r, tri_falling_nxt;
  logic signed [25:0] rect_counter_r, rect_counter_nxt;
  logic               rect_phase_r, rect_phase_nxt;
  logic               rect_negative_r, rect_negative_nxt;

  // Half counts depend on configuration only; register them
  logic [22:0] cnt0_r;
  logic [23:0] cnt1_r;
  logic [15:0] pw;
  logic [16:0] npw;
  logic [39:0] prod0;
  logic [40:0] prod1;

  logic signed [39:0] prod_amp;
  logic signed [24:0] scaled;
  logic signed [24:0] rect_amp;

  logic signed [25:0] v_ext, v_saw, saw_new, inc_s, tri_sum, tri_new;
  logic               tri_flip;
  logic signed [26:0] c_dec, c_rel, c_new;
  logic               rect_phase_t;

  assign pw    = {~cfg.pulse_width[15], cfg.pulse_width[14:0]};
  assign npw   = 17'd65536 - {1'b0, pw};
  assign prod0 = {16'b0, cfg.half_period} * {24'b0, pw};
  assign prod1 = {17'b0, cfg.half_period} * {24'b0, npw};

  always_ff @(posedge clk) begin
    cnt0_r <= prod0[39:17];
    cnt1_r <= prod1[40:17];
  end

  // Sample of the current state
  assign prod_amp = 40'(osc_value_r) * 40'(cfg.amplitude);
  assign scaled   = prod_amp[39:15];
  assign rect_amp = 25'($signed({cfg.amplitude, 5'b0}));

  always_comb begin
    case (cfg.wave_mode)
      mwo_pkg::MODE_SAW,
      mwo_pkg::MODE_TRI:  osc = scaled;
      mwo_pkg::MODE_RECT: osc = rect_negative_r ? -rect_amp : rect_amp;
      default:            osc = '0;
    endcase
  end

  // Saw: always the positive step, wrap above +1
  assign v_ext   = 26'(osc_value_r);
  assign v_saw   = v_ext + $signed({4'b0, cfg.phase_step});
  assign saw_new = (v_saw > mwo_pkg::Q_ONE) ? v_saw - mwo_pkg::Q_TWO : v_saw;

  // Triangle: double step, reflect at +1 and -1
  assign inc_s   = $signed({3'b0, cfg.phase_step, 1'b0});
  assign tri_sum = tri_falling_r ? v_ext - inc_s : v_ext + inc_s;

  always_comb begin
    tri_new  = tri_sum;
    tri_flip = 1'b0;
    if (tri_sum > mwo_pkg::Q_ONE) begin
      tri_new  = mwo_pkg::Q_TWO - tri_sum;
      tri_flip = 1'b1;
    end else if (tri_sum < -mwo_pkg::Q_ONE) begin
      tri_new  = -mwo_pkg::Q_TWO - tri_sum;
      tri_flip = 1'b1;
    end
  end

  // Rectangle: count down, reload the half selected by the new phase
  assign c_dec        = 27'(rect_counter_r) - mwo_pkg::CNT_DECR;
  assign rect_phase_t = ~rect_phase_r;
  assign c_rel        = c_dec + (rect_phase_t ? $signed({3'b0, cnt1_r})
                                              : $signed({4'b0, cnt0_r}));

  always_comb begin
    c_new = (c_dec <= 27'sd0) ? c_rel : c_dec;
    if (c_new < mwo_pkg::CNT_MIN) begin
      c_new = mwo_pkg::CNT_MIN;
    end
  end

  always_comb begin
    osc_value_nxt     = osc_value_r;
    tri_falling_nxt   = tri_falling_r;
    rect_counter_nxt  = rect_counter_r;
    rect_phase_nxt    = rect_phase_r;
    rect_negative_nxt = rect_negative_r;
    if (adv) begin
      case (cfg.wave_mode)
        mwo_pkg::MODE_SAW: begin
          osc_value_nxt = mwo_pkg::sat24(saw_new);
        end
        mwo_pkg::MODE_TRI: begin
          osc_value_nxt   = mwo_pkg::sat24(tri_new);
          tri_falling_nxt = tri_falling_r ^ tri_flip;
        end
        mwo_pkg::MODE_RECT: begin
          rect_counter_nxt = c_new[25:0];
          if (c_dec <= 27'sd0) begin
            rect_phase_nxt    = rect_phase_t;
            rect_negative_nxt = ~rect_negative_r;
          end
        end
        default: begin
          // unused mode: hold all state
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_value_r     <= '0;
      tri_falling_r   <= 1'b0;
      rect_counter_r  <= '0;
      rect_phase_r    <= 1'b0;
      rect_negative_r <= 1'b0;
    end else begin
      osc_value_r     <= osc_value_nxt;
      tri_falling_r   <= tri_falling_nxt;
      rect_counter_r  <= rect_counter_nxt;
      rect_phase_r    <= rect_phase_nxt;
      rect_negative_r <= rect_negative_nxt;
    end
  end

  // Phase and sign start together and toggle together
  a_phase_sign: assert property (@(posedge clk) disable iff (!rst_n)
    rect_phase_r == rect_negative_r)
    else $error("rectangle phase and sign diverged");

  a_hold_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(osc_value_r) && $stable(tri_falling_r) && $stable(rect_counter_r))
    else $error("oscillator state moved without a sample");

  a_rect_count: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cfg.wave_mode == mwo_pkg::MODE_RECT && rect_counter_r > 26'sd256
    |=> rect_counter_r == $past(rect_counter_r) - 26'sd256)
    else $error("rectangle counter did not count down by one sample");

endmodule

@@ hdl/multi_wave_audio_oscillator.sv @@
// Top level of the multi-wave audio oscillator: configuration registers, input
// register, mixing with saturation and the result register.
// Depends on mwo_pkg and mwo_gen.
//
//   channel  ports                                   direction
//   input    in_valid, in_stall, in_mix_in, in_replace  beat in, one sample tick each
//   result   out_valid, out_stall, out_sample_out     beat out, one per input beat
//   config   cfg_we, cfg_index, cfg_wdata             register write, no read-back
//
// One beat per cycle while out_stall is low; an accepted beat passes through the input
// register, then the generator and mix logic into the result register.
// Rectangle half counts are registered from the configuration registers.
// Reset (rst_n low, synchronous) clears configuration, except amplitude, which is set
// to AMP_RESET, and clears oscillator state and valids.
// out_stall holds the result register; in_stall rises only when both registers
// hold a beat and the result is stalled.
module multi_wave_audio_oscillator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [23:0]               in_mix_in,
  input  logic                             in_replace,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [23:0]               out_sample_out,
  input  logic                             cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  mwo_pkg::cfg_t cfg_r;

  logic               in_valid_r;
  logic signed [23:0] mix_r;
  logic               replace_r;
  logic               out_valid_r;
  logic signed [23:0] sample_r;

  logic               adv;
  logic               out_free;
  logic               in_take;
  logic signed [24:0] osc;
  logic signed [25:0] mix_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_mode   <= mwo_pkg::MODE_SAW;
      cfg_r.amplitude   <= mwo_pkg::AMP_RESET;
      cfg_r.phase_step  <= '0;
      cfg_r.half_period <= '0;
      cfg_r.pulse_width <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mwo_pkg::REG_WAVE_MODE:   cfg_r.wave_mode   <= cfg_wdata[1:0];
        mwo_pkg::REG_AMPLITUDE:   cfg_r.amplitude   <= cfg_wdata[15:0];
        mwo_pkg::REG_PHASE_STEP:  cfg_r.phase_step  <= cfg_wdata[21:0];
        mwo_pkg::REG_HALF_PERIOD: cfg_r.half_period <= cfg_wdata[23:0];
        mwo_pkg::REG_PULSE_WIDTH: cfg_r.pulse_width <= cfg_wdata[15:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mix_r     <= in_mix_in;
      replace_r <= in_replace;
    end
  end

  mwo_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .adv   (adv),
    .osc   (osc)
  );

  assign mix_sum = replace_r ? 26'(osc) : 26'(mix_r) + 26'(osc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r <= mwo_pkg::sat24(mix_sum);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled while a register was free");

  a_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(mix_r) && $stable(replace_r))
    else $error("pending input beat lost");

  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced beat missing from result register");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for multi_wave_audio_oscillator: directed and random sample
// beats with random idling, each result compared against an in-bench wave predictor.
// Depends on mwo_pkg and the RTL top level; reads and writes no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                    MODE_OFF    = 2'd3;
  localparam logic [mwo_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam longint                        ONE_Q20     = 1048576;
  localparam longint                        COUNT_FLOOR = -33554432;
  localparam longint                        COUNT_STEP  = 256;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [23:0]             in_mix_in = '0;
  logic                           in_replace = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [23:0]             out_sample_out;
  logic                           cfg_we = 1'b0;
  logic [mwo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies and oscillator state as they stand after reset
  logic [1:0]         mode_m = mwo_pkg::MODE_SAW;
  logic signed [15:0] amp_m = mwo_pkg::AMP_RESET;
  logic [21:0]        step_m = '0;
  logic [23:0]        hp_m = '0;
  logic signed [15:0] pw_m = '0;
  logic signed [23:0] osc_m = '0;
  logic               falling_m = 1'b0;
  longint             count_m = 0;
  logic               phase_m = 1'b0;
  logic               negative_m = 1'b0;

  logic signed [23:0] expected_samples[$];
  int                 n_errors = 0;
  bit                 idle_en = 1'b0;
  int                 hold_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multi_wave_audio_oscillator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mix_in      (in_mix_in),
    .in_replace     (in_replace),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  function automatic logic signed [23:0] clamp_s24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Form the oscillator sample from the current state, then advance the state
  function automatic logic signed [23:0] predict_sample(logic signed [23:0] mix, logic rep);
    longint v, osc, st, inc, c, pw, hp, cnt0, cnt1;
    v = osc_m;
    st = step_m;
    hp = hp_m;
    osc = 0;
    case (mode_m)
      mwo_pkg::MODE_SAW: begin
        osc = (v * amp_m) >>> 15;
        v = v + st;
        if (v > ONE_Q20) v = v - 2 * ONE_Q20;
        osc_m = clamp_s24(v);
      end
      mwo_pkg::MODE_TRI: begin
        osc = (v * amp_m) >>> 15;
        inc = 2 * st;
        v = falling_m ? v - inc : v + inc;
        if (v > ONE_Q20) begin
          v = 2 * ONE_Q20 - v;
          falling_m = ~falling_m;
        end else if (v < -ONE_Q20) begin
          v = -2 * ONE_Q20 - v;
          falling_m = ~falling_m;
        end
        osc_m = clamp_s24(v);
      end
      mwo_pkg::MODE_RECT: begin
        pw = pw_m;
        pw = pw + 32768;
        cnt0 = (hp * pw) >>> 17;
        cnt1 = (hp * (65536 - pw)) >>> 17;
        osc = amp_m;
        osc = osc * 32;
        if (negative_m) osc = -osc;
        c = count_m - COUNT_STEP;
        if (c <= 0) begin
          phase_m = ~phase_m;
          c = c + (phase_m ? cnt1 : cnt0);
          negative_m = ~negative_m;
        end
        if (c < COUNT_FLOOR) c = COUNT_FLOOR;
        count_m = c;
      end
      default: ;
    endcase
    return clamp_s24(rep ? osc : longint'(mix) + osc);
  endfunction

  function automatic logic signed [23:0] pick_mix();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      default: return 24'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin : check_output
    logic signed [23:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected output beat: sample_out %0d", out_sample_out);
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_out !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("sample_out mismatch: expected %0d, got %0d", want, out_sample_out);
          end
        end
      end
    end
  end

  // Receiver: long hold-off on request, else short random stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(logic signed [23:0] mix, logic rep);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_mix_in <= 24'($urandom);
      in_replace <= 1'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mix_in <= mix;
    in_replace <= rep;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(predict_sample(mix, rep));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [mwo_pkg::CFG_IDX_W-1:0] idx,
                           logic [mwo_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_index <= 3'($urandom);
    cfg_wdata <= 24'($urandom);
    @(negedge clk);
    case (idx)
      mwo_pkg::REG_WAVE_MODE:   mode_m = data[1:0];
      mwo_pkg::REG_AMPLITUDE:   amp_m = data[15:0];
      mwo_pkg::REG_PHASE_STEP:  step_m = data[21:0];
      mwo_pkg::REG_HALF_PERIOD: hp_m = data[23:0];
      mwo_pkg::REG_PULSE_WIDTH: pw_m = data[15:0];
      default: ;
    endcase
  endtask

  // Wait for idle, then write every register; junk rides in the unused upper bits
  task automatic configure(logic [1:0] mode, logic signed [15:0] amp, logic [21:0] step,
                           logic [23:0] hp, logic signed [15:0] pw);
    drain();
    write_reg(mwo_pkg::REG_WAVE_MODE, {22'($urandom), mode});
    write_reg(mwo_pkg::REG_AMPLITUDE, {8'($urandom), amp});
    write_reg(mwo_pkg::REG_PHASE_STEP, {2'($urandom), step});
    write_reg(mwo_pkg::REG_HALF_PERIOD, hp);
    write_reg(mwo_pkg::REG_PULSE_WIDTH, {8'($urandom), pw});
  endtask

  task automatic test_reset_values();
    send_sample(24'sd0, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sd123, 1'b1);
  endtask

  task automatic test_saw();
    configure(mwo_pkg::MODE_SAW, 16'sh8000, 22'd262144, 24'd0, 16'sd0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 24'sh800000 : 24'sh7FFFFF, i == 5);
    configure(mwo_pkg::MODE_SAW, 16'sh7FFF, 22'h3FFFFF, 24'd0, 16'sd0);
    repeat (2) send_sample(pick_mix(), 1'b0);
  endtask

  task automatic test_triangle();
    configure(mwo_pkg::MODE_TRI, 16'sh7FFF, 22'd524288, 24'd0, 16'sd0);
    repeat (5) send_sample(24'sd0, 1'b1);
    // oversized step drives the value into saturation
    configure(mwo_pkg::MODE_TRI, 16'sh7FFF, 22'h3FFFFF, 24'd0, 16'sd0);
    repeat (3) send_sample(24'sd0, 1'b1);
    // saw keeps the positive step whatever the triangle direction
    configure(mwo_pkg::MODE_SAW, 16'sh7FFF, 22'd100000, 24'd0, 16'sd0);
    repeat (2) send_sample(24'sd0, 1'b1);
  endtask

  task automatic test_rectangle();
    configure(mwo_pkg::MODE_RECT, 16'sh8000, 22'd0, 24'd2048, 16'sh7FFF);
    for (int i = 0; i < 6; i++) send_sample(pick_mix(), i[0]);
    configure(mwo_pkg::MODE_RECT, 16'sh7FFF, 22'd0, 24'hFFFFFF, 16'sh8000);
    repeat (3) send_sample(24'sh7FFFFF, 1'b0);
  endtask

  task automatic test_unused_mode();
    configure(MODE_OFF, 16'sh7FFF, 22'd1000, 24'd2048, 16'sd0);
    write_reg(REG_UNUSED, 24'($urandom));
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sd555, 1'b1);
  endtask

  // Zero counts: the counter walks down by one sample per beat
  task automatic test_counter_runaway();
    configure(mwo_pkg::MODE_RECT, 16'sd20000, 22'd0, 24'd0, 16'sd0);
    idle_en = 1'b0;
    repeat (100) send_sample(pick_mix(), 1'b0);
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(mwo_pkg::MODE_TRI, 16'sh7FFF, 22'd30000, 24'd0, 16'sd0);
    hold_cycles = 60;
    repeat (40) send_sample(pick_mix(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random(int phases, int beats);
    logic [1:0]         mode;
    logic signed [15:0] amp, pw;
    logic [21:0]        step;
    logic [23:0]        hp;
    for (int p = 0; p < phases; p++) begin
      mode = ($urandom_range(0, 9) == 0) ? MODE_OFF : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        0: amp = 16'sh8000;
        1: amp = 16'sh7FFF;
        default: amp = 16'($urandom);
      endcase
      step = ($urandom_range(0, 5) == 0) ? 22'($urandom) : 22'($urandom_range(0, 65536));
      hp = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 16384));
      case ($urandom_range(0, 5))
        0: pw = 16'sh8000;
        1: pw = 16'sh7FFF;
        default: pw = 16'($urandom);
      endcase
      configure(mode, amp, step, hp, pw);
      // no idling in the closing phases
      idle_en = (p < phases - 2);
      repeat (beats) send_sample(pick_mix(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    #6ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_en = 1'b1;
    test_reset_values();
    test_saw();
    test_triangle();
    test_rectangle();
    test_unused_mode();
    test_counter_runaway();
    test_backpressure();
    test_random(16, 40);
    drain();
    repeat (8) @(negedge clk);
    if (n_errors == 0 && expected_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
